FILE: rtl/segsh_pkg.sv
package segsh_pkg;

  localparam int unsigned FRAME_BITS  = 24;
  localparam int unsigned DIGIT_BITS  = 8;
  localparam int unsigned DIGIT_COUNT = 3;

  localparam logic [15:0] ONE_THOUSAND = 16'd1000;
  localparam logic [7:0]  SEG_BLANK    = 8'hFF;
  localparam logic [7:0]  SEG_DOT_MASK = 8'hFD;

  localparam logic [1:0] MODE_PLAIN = 2'd1;
  localparam logic [1:0] MODE_DOT   = 2'd2;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  display_mode;
  } in_t;

  typedef struct packed {
    logic       serial_bit;
    logic [1:0] digit_index;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic       serial_bit;
    logic [1:0] digit_index;
    logic       last;
  } cell_t;

  typedef struct packed {
    logic                                   valid;
    logic [DIGIT_COUNT-1:0][DIGIT_BITS-1:0] code;
  } frame_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'h0: code = 8'h22;
      4'h1: code = 8'h7E;
      4'h2: code = 8'h13;
      4'h3: code = 8'h1A;
      4'h4: code = 8'h4E;
      4'h5: code = 8'h8A;
      4'h6: code = 8'h82;
      4'h7: code = 8'h3E;
      4'h8: code = 8'h02;
      4'h9: code = 8'h0A;
      4'hA: code = 8'h06;
      4'hB: code = 8'hC2;
      4'hC: code = 8'hA3;
      4'hD: code = 8'h52;
      4'hE: code = 8'h83;
      4'hF: code = 8'h87;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/seven_segment_number_shifter_unit.sv
// Seven-segment number shifter. Each input transfer carries a 16-bit value
// and a display mode and becomes 24 output transfers, one serial segment bit
// each: the ones, tens and hundreds digit bytes in that order, each byte MSB
// first, with last set on the 24th bit so that the external latch can follow.
// Modes 0 and 3 produce no output unless the value is exactly one thousand.
// An input passes three register stages (input register, hundreds estimate,
// tens estimate and segment lookup) and is then loaded in parallel into a
// row of 24 bit cells that shifts toward the output once per transfer.
// The first bit is presented once the frame is loaded into the cells.
// Throughput is set by the bit chain: the next frame is loaded in the cycle
// its predecessor's last bit leaves, so frames follow with no gap, while
// up to three more items wait in the stages.
// Items that produce nothing leave the stages at one per cycle.
// When out_stall is high the chain holds; the stages fill and in_stall rises.
// Reset empties the stages and the chain; no output is valid after reset.
module seven_segment_number_shifter_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  segsh_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output segsh_pkg::out_t out_data
);

  segsh_pkg::frame_t frame;
  segsh_pkg::cell_t  cells [segsh_pkg::FRAME_BITS];
  logic              chain_ready, shift, load;

  assign out_valid   = cells[0].valid;
  assign shift       = out_valid && !out_stall;
  assign chain_ready = !cells[0].valid || (cells[0].last && shift);
  assign load        = frame.valid && chain_ready;

  assign out_data.serial_bit  = cells[0].serial_bit;
  assign out_data.digit_index = cells[0].digit_index;
  assign out_data.last        = cells[0].last;

  segsh_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .chain_ready(chain_ready),
    .frame      (frame)
  );

  for (genvar k = 0; k < segsh_pkg::FRAME_BITS; k++) begin : g_cell
    segsh_pkg::cell_t ld, nx;

    assign ld.valid       = 1'b1;
    assign ld.serial_bit  = frame.code[k / segsh_pkg::DIGIT_BITS]
                                      [segsh_pkg::DIGIT_BITS - 1 - (k % segsh_pkg::DIGIT_BITS)];
    assign ld.digit_index = 2'(k / segsh_pkg::DIGIT_BITS);
    assign ld.last        = (k == segsh_pkg::FRAME_BITS - 1);

    if (k == segsh_pkg::FRAME_BITS - 1) begin : g_tail
      assign nx = '0;
    end else begin : g_body
      assign nx = cells[k + 1];
    end

    segsh_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (load),
      .shift    (shift),
      .load_data(ld),
      .next_data(nx),
      .cell_q   (cells[k])
    );
  end

endmodule

FILE: rtl/segsh_encode.sv
module segsh_encode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  segsh_pkg::in_t    in_data,
  input  logic              chain_ready,
  output segsh_pkg::frame_t frame
);

  logic           st1_v_r, st1_v_nxt;
  segsh_pkg::in_t st1_r;

  logic        st2_v_r, st2_v_nxt;
  logic [11:0] st2_val_r;
  logic [1:0]  st2_mode_r;
  logic        st2_hex_r, st2_k_r;
  logic [3:0]  st2_q_r;

  logic        st3_v_r, st3_v_nxt;
  logic [11:0] st3_val_r;
  logic [1:0]  st3_mode_r;
  logic        st3_hex_r, st3_k_r;
  logic [3:0]  st3_q_r;
  logic [6:0]  st3_r_r;
  logic [3:0]  st3_t_r;

  logic        st1_free, st2_free, st3_free, st3_take, st3_emit;
  logic [15:0] prod1;
  logic [11:0] rem2;
  logic [14:0] prod2;
  logic [6:0]  ones3;
  logic [3:0]  d0, d1, d2;
  logic [7:0]  c0, c1, c2;

  always_comb begin
    st3_emit = st3_k_r || (st3_mode_r == segsh_pkg::MODE_PLAIN) ||
               (st3_mode_r == segsh_pkg::MODE_DOT);
    st3_take = st3_v_r && (!st3_emit || chain_ready);
    st3_free = !st3_v_r || st3_take;
    st2_free = !st2_v_r || st3_free;
    st1_free = !st1_v_r || st2_free;
    in_stall = !st1_free;
    st1_v_nxt = in_valid ? 1'b1 : (st1_v_r && !st2_free);
    st2_v_nxt = st2_free ? st1_v_r : st2_v_r;
    st3_v_nxt = st3_free ? st2_v_r : st3_v_r;
  end

  assign prod1 = {6'd0, st1_r.value[9:0]} * 16'd41;
  assign rem2  = {2'd0, st2_val_r[9:0]} - ({8'd0, st2_q_r} * 12'd100);
  assign prod2 = {8'd0, rem2[6:0]} * 15'd205;
  assign ones3 = st3_r_r - ({3'd0, st3_t_r} * 7'd10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
      st2_v_r <= 1'b0;
      st3_v_r <= 1'b0;
    end else begin
      st1_v_r <= st1_v_nxt;
      st2_v_r <= st2_v_nxt;
      st3_v_r <= st3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && st1_free) begin
      st1_r <= in_data;
    end
    if (st2_free) begin
      st2_val_r  <= st1_r.value[11:0];
      st2_mode_r <= st1_r.display_mode;
      st2_hex_r  <= st1_r.value > segsh_pkg::ONE_THOUSAND;
      st2_k_r    <= st1_r.value == segsh_pkg::ONE_THOUSAND;
      st2_q_r    <= prod1[15:12];
    end
    if (st3_free) begin
      st3_val_r  <= st2_val_r;
      st3_mode_r <= st2_mode_r;
      st3_hex_r  <= st2_hex_r;
      st3_k_r    <= st2_k_r;
      st3_q_r    <= st2_q_r;
      st3_r_r    <= rem2[6:0];
      st3_t_r    <= prod2[14:11];
    end
  end

  always_comb begin
    d0 = st3_hex_r ? st3_val_r[3:0]  : ones3[3:0];
    d1 = st3_hex_r ? st3_val_r[7:4]  : st3_t_r;
    d2 = st3_hex_r ? st3_val_r[11:8] : st3_q_r;
    c0 = segsh_pkg::seg_code(d0);
    c1 = segsh_pkg::seg_code(d1);
    c2 = (d2 == 4'd0) ? segsh_pkg::SEG_BLANK : segsh_pkg::seg_code(d2);
    if (st3_k_r) begin
      c0 = segsh_pkg::seg_code(4'd9);
      c1 = segsh_pkg::seg_code(4'd9);
      c2 = segsh_pkg::seg_code(4'd9);
    end else if (st3_mode_r == segsh_pkg::MODE_DOT) begin
      c1 = c1 & segsh_pkg::SEG_DOT_MASK;
    end else if (d1 == 4'd0 && d2 == 4'd0) begin
      c1 = segsh_pkg::SEG_BLANK;
    end
    frame.valid   = st3_v_r && st3_emit;
    frame.code[0] = c0;
    frame.code[1] = c1;
    frame.code[2] = c2;
  end

endmodule

FILE: rtl/segsh_cell.sv
module segsh_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             shift,
  input  segsh_pkg::cell_t load_data,
  input  segsh_pkg::cell_t next_data,
  output segsh_pkg::cell_t cell_q
);

  segsh_pkg::cell_t cell_r, cell_nxt;

  always_comb begin
    if (load) begin
      cell_nxt = load_data;
    end else if (shift) begin
      cell_nxt = next_data;
    end else begin
      cell_nxt = cell_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.serial_bit  <= cell_nxt.serial_bit;
    cell_r.digit_index <= cell_nxt.digit_index;
    cell_r.last        <= cell_nxt.last;
  end

  assign cell_q = cell_r;

endmodule
